[src/amcv_pkg.sv]
// Package: constants, types and CRC step for the archive member chain validator.
`timescale 1ns / 1ps
package amcv_pkg;
	localparam int POS_BITS = 40;
	localparam int CNT_BITS = 17;
	localparam logic [POS_BITS-1:0] POS_TOP = {POS_BITS{1'b1}};
	localparam logic [CNT_BITS-1:0] CNT_TOP = {CNT_BITS{1'b1}};
	localparam logic [31:0] LEAD_CONTAINER = 32'h0204_5767;
	localparam logic [31:0] LEAD_MEMBER = 32'h0104_5767;
	localparam logic [7:0] SIG_A = 8'h30;
	localparam logic [7:0] SIG_B = 8'h31;
	localparam logic [7:0] METH_STORED = 8'h01;
	localparam logic [7:0] METH_CRUSHED = 8'h02;
	localparam logic [7:0] CHAR_LOW = 8'h20;
	localparam logic [7:0] CHAR_HIGH = 8'h7e;
	localparam logic [5:0] TRAILER_LEN = 6'd33;
	localparam logic [15:0] DEF_MAX_NAME = 16'd4096;
	localparam logic [16:0] DEF_MAX_MEMBERS = 17'd100000;

	localparam logic CFG_MAX_NAME = 1'b0;
	localparam logic CFG_MAX_MEMBERS = 1'b1;

	typedef enum logic [3:0] {
		ERR_OK = 4'd0, ERR_LEAD = 4'd1, ERR_PRELUDE = 4'd2, ERR_MAGIC = 4'd3,
		ERR_TERM = 4'd4, ERR_NAME_LONG = 4'd5, ERR_NAME_CHAR = 4'd6,
		ERR_RESERVED = 4'd7, ERR_METHOD = 4'd8, ERR_STORED = 4'd9,
		ERR_CRC = 4'd10, ERR_TOTAL = 4'd11, ERR_COUNT = 4'd12,
		ERR_TRUNC = 4'd13, ERR_POS = 4'd14
	} err_t;

	typedef enum logic [8:0] {
		PH_WAIT = 9'b000000001, PH_LEAD = 9'b000000010, PH_PRELUDE = 9'b000000100,
		PH_PREFIX = 9'b000001000, PH_NAME = 9'b000010000, PH_TRAILER = 9'b000100000,
		PH_PAYLOAD = 9'b001000000, PH_TERM = 9'b010000000, PH_DONE = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic start_of_file;
		logic end_of_file;
	} in_beat_t;

	typedef struct packed {
		logic archive_valid;
		logic [3:0] error_code;
		logic [39:0] archive_size;
		logic [16:0] member_count;
		logic has_container;
	} out_beat_t;

	typedef struct packed {
		logic index;
		logic [16:0] data;
	} cfg_beat_t;

	// One reflected CRC-32 byte step, eight bit steps
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (32'hEDB8_8320 & {32{c[0]}});
		end
		return c;
	endfunction
endpackage

[src/amcv_if.sv]
// Valid/ready channel interfaces for data, result and configuration beats.
`timescale 1ns / 1ps
interface amcv_in_if;
	logic valid;
	logic ready;
	amcv_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface amcv_out_if;
	logic valid;
	logic ready;
	amcv_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface amcv_cfg_if;
	logic valid;
	logic ready;
	amcv_pkg::cfg_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/archive_member_chain_validator.sv]
// Top level: byte-serial archive member chain validator.
//  channel | dir | payload
//  in_ch   | in  | data_byte, start_of_file, end_of_file
//  out_ch  | out | archive_valid, error_code, archive_size, member_count, has_container
//  cfg_ch  | in  | index (0 max_name_length, 1 max_member_count), data
// One byte a cycle unless in_ch stalls: the parse state updates in the same cycle a beat is accepted.
// A verdict goes to a one-entry output register; in_ch stalls only while that
// register is full and not being taken. The verdict is registered from the byte that decides it.
// Reset (arst_n low) clears all state but the verdict data and loads register defaults; cfg is always ready.
`timescale 1ns / 1ps
module archive_member_chain_validator (
	input logic clk,
	input logic arst_n,
	amcv_in_if.sink in_ch,
	amcv_out_if.source out_ch,
	amcv_cfg_if.sink cfg_ch
);
	import amcv_pkg::*;

	logic [15:0] max_name_q;
	logic [16:0] max_mem_q;
	phase_t ph_q, ph_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [15:0] idx_q, idx_d;
	logic [31:0] sh_q, sh_d, decl_q, decl_d;
	logic [32:0] usum_q, usum_d;
	logic [CNT_BITS-1:0] seen_q, seen_d;
	logic [15:0] nlen_q, nlen_d;
	logic [31:0] prem_q, prem_d, uheld_q, uheld_d, ecrc_q, ecrc_d, crc_q, crc_d;
	logic stored_q, stored_d, cont_q, cont_d, done_q, done_d, rbad_q, rbad_d;
	logic ovalid_q;
	out_beat_t obeat_q;
	logic fire, emit;
	err_t code;
	logic [39:0] size;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready = !ovalid_q || out_ch.ready;
	assign fire = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = obeat_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_q <= DEF_MAX_NAME;
			max_mem_q <= DEF_MAX_MEMBERS;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				CFG_MAX_NAME: max_name_q <= cfg_ch.data.data[15:0];
				CFG_MAX_MEMBERS: max_mem_q <= cfg_ch.data.data;
				default: ;
			endcase
		end
	end

	// Parse step for one byte
	always_comb begin
		logic [7:0] b;
		logic [31:0] acc;
		logic [15:0] idx1;
		logic go;
		logic fin;
		logic [32:0] sum_n;
		logic [CNT_BITS-1:0] seen_n;
		b = in_ch.data.data_byte;
		ph_d = ph_q; pos_d = pos_q; idx_d = idx_q; sh_d = sh_q; decl_d = decl_q;
		usum_d = usum_q; seen_d = seen_q; nlen_d = nlen_q; prem_d = prem_q;
		uheld_d = uheld_q; ecrc_d = ecrc_q; crc_d = crc_q; stored_d = stored_q;
		cont_d = cont_q; done_d = done_q; rbad_d = rbad_q;
		emit = 1'b0; code = ERR_OK; size = '0; go = 1'b1; fin = 1'b0;
		sum_n = '0; seen_n = '0;
		if (in_ch.data.start_of_file || ph_q == PH_WAIT) begin
			ph_d = PH_LEAD; pos_d = '0; idx_d = '0; sh_d = '0; decl_d = '0;
			usum_d = '0; seen_d = '0; nlen_d = '0; prem_d = '0; uheld_d = '0;
			ecrc_d = '0; crc_d = '1; stored_d = 1'b0; cont_d = 1'b0;
			done_d = 1'b0; rbad_d = 1'b0;
		end
		idx1 = idx_d + 16'd1;
		acc = {b, sh_d[31:8]};
		if (!done_d) begin
			if (pos_d == POS_TOP) begin
				go = 1'b0; code = ERR_POS;
			end else begin
				pos_d = pos_d + POS_BITS'(1);
				case (ph_d)
					PH_LEAD: begin
						sh_d = acc; idx_d = idx1;
						if (idx1 >= 16'd4) begin
							if (acc == LEAD_CONTAINER) begin
								cont_d = 1'b1; ph_d = PH_PRELUDE;
							end else if (acc == LEAD_MEMBER) begin
								ph_d = PH_PREFIX;
								if (seen_d >= max_mem_q) begin
									go = 1'b0; code = ERR_COUNT;
								end
							end else begin
								go = 1'b0; code = ERR_LEAD;
							end
						end
					end
					PH_PRELUDE: begin
						if (idx_d < 16'd8) begin
							sh_d = acc;
							if (idx_d == 16'd7) decl_d = acc;
						end else if (b != 8'd0) begin
							go = 1'b0; code = ERR_PRELUDE;
						end
						if (go) begin
							idx_d = idx1;
							if (idx1 >= 16'd12) begin
								ph_d = PH_PREFIX; idx_d = '0; sh_d = '0;
								if (seen_d >= max_mem_q) begin
									go = 1'b0; code = ERR_COUNT;
								end
							end
						end
					end
					PH_PREFIX: begin
						sh_d = acc;
						if ((idx_d == 16'd3 && acc != LEAD_MEMBER) ||
						    (idx_d == 16'd4 && b != SIG_A && b != SIG_B)) begin
							go = 1'b0; code = ERR_MAGIC;
						end else if (idx_d < 16'd7) begin
							idx_d = idx1;
						end else begin
							idx_d = '0;
							nlen_d = acc[31:16];
							if (acc[31:16] == 16'd0) begin
								if (seen_d == '0 ||
								    (cont_d && usum_d != {1'b0, decl_d})) begin
									go = 1'b0; code = ERR_TERM;
								end else begin
									ph_d = PH_TERM;
								end
							end else if (acc[31:16] > max_name_q) begin
								go = 1'b0; code = ERR_NAME_LONG;
							end else begin
								ph_d = PH_NAME;
							end
						end
					end
					PH_NAME: begin
						if (b < CHAR_LOW || b > CHAR_HIGH) begin
							go = 1'b0; code = ERR_NAME_CHAR;
						end else begin
							idx_d = idx1;
							if (idx1 >= nlen_d) begin
								ph_d = PH_TRAILER; idx_d = '0; sh_d = '0; rbad_d = 1'b0;
							end
						end
					end
					PH_TRAILER: begin
						sh_d = acc;
						if (((idx_d >= 16'd6 && idx_d <= 16'd9) || idx_d >= 16'd25) &&
						    b != 8'd0) rbad_d = 1'b1;
						if (idx_d == 16'd13) prem_d = acc;
						if (idx_d == 16'd17) uheld_d = acc;
						if (idx_d == 16'd21) ecrc_d = acc;
						if (idx_d == 16'd22) begin
							if (b != METH_STORED && b != METH_CRUSHED) begin
								go = 1'b0; code = ERR_METHOD;
							end
							stored_d = (b == METH_STORED);
						end
						if (go) begin
							if (idx1 < {10'd0, TRAILER_LEN}) begin
								idx_d = idx1;
							end else if (rbad_d) begin
								go = 1'b0; code = ERR_RESERVED;
							end else if (stored_d && prem_d != uheld_d) begin
								go = 1'b0; code = ERR_STORED;
							end else begin
								crc_d = '1; idx_d = '0;
								if (prem_d == 32'd0) fin = 1'b1;
								else ph_d = PH_PAYLOAD;
							end
						end
					end
					PH_PAYLOAD: begin
						crc_d = crc_byte(crc_d, b);
						prem_d = prem_d - 32'd1;
						if (prem_d == 32'd0) fin = 1'b1;
					end
					PH_TERM: begin
						idx_d = idx1;
						if (idx1 >= {10'd0, TRAILER_LEN}) begin
							go = 1'b0; code = ERR_OK;
							size = pos_d[39:0];
						end
					end
					default: ;
				endcase
				// End of member: CRC, total, count
				if (fin) begin
					sum_n = usum_d + {1'b0, uheld_d};
					seen_n = (seen_d < CNT_TOP) ? seen_d + CNT_BITS'(1) : seen_d;
					if ((crc_d ^ 32'hFFFF_FFFF) != ecrc_d) begin
						go = 1'b0; code = ERR_CRC;
					end else begin
						if (cont_d) usum_d = sum_n;
						if (cont_d && sum_n > {1'b0, decl_d}) begin
							go = 1'b0; code = ERR_TOTAL;
						end else begin
							seen_d = seen_n;
							if (seen_n >= max_mem_q || seen_n >= CNT_TOP) begin
								go = 1'b0; code = ERR_COUNT;
							end else begin
								ph_d = PH_PREFIX; idx_d = '0; sh_d = '0;
							end
						end
					end
				end
			end
			if (go && in_ch.data.end_of_file) begin
				go = 1'b0; code = ERR_TRUNC;
			end
			if (!go) begin
				emit = 1'b1; done_d = 1'b1; ph_d = PH_DONE;
			end
		end
	end

	// Parse state and verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_WAIT; pos_q <= '0; idx_q <= '0; sh_q <= '0; decl_q <= '0;
			usum_q <= '0; seen_q <= '0; nlen_q <= '0; prem_q <= '0; uheld_q <= '0;
			ecrc_q <= '0; crc_q <= '1; stored_q <= 1'b0; cont_q <= 1'b0;
			done_q <= 1'b0; rbad_q <= 1'b0; ovalid_q <= 1'b0;
		end else begin
			if (out_ch.ready) ovalid_q <= 1'b0;
			if (fire) begin
				ph_q <= ph_d; pos_q <= pos_d; idx_q <= idx_d; sh_q <= sh_d;
				decl_q <= decl_d; usum_q <= usum_d; seen_q <= seen_d; nlen_q <= nlen_d;
				prem_q <= prem_d; uheld_q <= uheld_d; ecrc_q <= ecrc_d; crc_q <= crc_d;
				stored_q <= stored_d; cont_q <= cont_d; done_q <= done_d;
				rbad_q <= rbad_d;
				if (emit) ovalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			obeat_q.archive_valid <= (code == ERR_OK);
			obeat_q.error_code <= code;
			obeat_q.archive_size <= size;
			obeat_q.member_count <= seen_d;
			obeat_q.has_container <= cont_d;
		end
	end
endmodule

[src/amcv_checker.sv]
// Port-level checker for the archive member chain validator, with its bind.
`timescale 1ns / 1ps
module amcv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_ok,
	input logic [3:0] out_code,
	input logic [39:0] out_size
);
	import amcv_pkg::*;

	// A verdict's valid flag agrees with its code
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_ok == (out_code == ERR_OK))) else $error("ok flag/code mismatch");
	// Size is nonzero only on a good verdict
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ok) |-> (out_size == 40'd0)) else $error("size on failure");
	// Input stalls only behind a held verdict
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready)) else $error("spurious stall");
	// A held verdict stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("verdict dropped");
endmodule

bind archive_member_chain_validator amcv_checker u_amcv_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_ok(out_ch.data.archive_valid), .out_code(out_ch.data.error_code),
	.out_size(out_ch.data.archive_size)
);
